[sv/urra_pkg.sv]
`default_nettype none

package urra_pkg;

    // child table size and derived widths
    localparam int MAX_CHILDREN    = 16;
    localparam int CNT_W           = $clog2(MAX_CHILDREN + 1);
    localparam int IDX_W           = (MAX_CHILDREN > 1) ? $clog2(MAX_CHILDREN) : 1;
    localparam int CHILD_IDX_W     = 8;

    // field widths
    localparam int ADDR_W          = 32;
    localparam int LOG2_W          = 5;
    localparam int LG_W            = 6;
    localparam int SIZE_W          = 38;
    localparam int ACT_W           = 5;
    localparam int CNODE_SLOT_LOG2 = 4;

    // register reset values
    localparam logic [ADDR_W-1:0] RST_BASE_ADDRESS = '0;
    localparam logic [LOG2_W-1:0] RST_REGION_LOG2  = 5'd12;
    localparam logic [LOG2_W-1:0] RST_ENDPOINT     = 5'd4;
    localparam logic [LOG2_W-1:0] RST_NOTIFICATION = 5'd4;
    localparam logic [LOG2_W-1:0] RST_THREAD_BLOCK = 5'd9;
    localparam logic [LOG2_W-1:0] RST_FRAME        = 5'd12;
    localparam logic [LOG2_W-1:0] RST_PAGE_TABLE   = 5'd12;

    typedef enum logic [1:0] {
        OP_RETYPE,
        OP_PROBE,
        OP_REVOKE_ALL,
        OP_REVOKE_ONE
    } t_op;

    typedef enum logic [2:0] {
        OBJ_ENDPOINT,
        OBJ_NOTIFICATION,
        OBJ_THREAD_BLOCK,
        OBJ_CNODE,
        OBJ_FRAME,
        OBJ_PAGE_TABLE,
        OBJ_UNTYPED,
        OBJ_INVALID
    } t_obj;

    typedef enum logic [2:0] {
        CFG_BASE_ADDRESS,
        CFG_REGION_SIZE_LOG2,
        CFG_DEVICE_REGION,
        CFG_ENDPOINT_SIZE_LOG2,
        CFG_NOTIFICATION_SIZE_LOG2,
        CFG_THREAD_BLOCK_SIZE_LOG2,
        CFG_FRAME_SIZE_LOG2,
        CFG_PAGE_TABLE_SIZE_LOG2
    } t_cfg_idx;

    typedef struct packed {
        logic [ADDR_W-1:0] base_address;
        logic [LOG2_W-1:0] region_size_log2;
        logic              device_region;
        logic [LOG2_W-1:0] endpoint_size_log2;
        logic [LOG2_W-1:0] notification_size_log2;
        logic [LOG2_W-1:0] thread_block_size_log2;
        logic [LOG2_W-1:0] frame_size_log2;
        logic [LOG2_W-1:0] page_table_size_log2;
    } t_cfg;

    typedef struct packed {
        t_op                    operation;
        t_obj                   object_type;
        logic [LOG2_W-1:0]      object_size_log2;
        logic [CHILD_IDX_W-1:0] child_index;
    } t_req;

    typedef struct packed {
        logic              dev_region;
        logic              has_children;
        logic [ACT_W-1:0]  active_children;
        logic [ADDR_W-1:0] bytes_remaining;
        logic [ADDR_W-1:0] object_address;
        logic              ok;
    } t_rsp;

    // log2 of object size, top bit set when the type is valid
    function automatic logic [LG_W:0] obj_log2(t_cfg cfg, t_obj ty, logic [LOG2_W-1:0] sz);
        logic [LG_W:0] res;
        res = '0;
        case (ty)
            OBJ_ENDPOINT:     res = {1'b1, LG_W'(cfg.endpoint_size_log2)};
            OBJ_NOTIFICATION: res = {1'b1, LG_W'(cfg.notification_size_log2)};
            OBJ_THREAD_BLOCK: res = {1'b1, LG_W'(cfg.thread_block_size_log2)};
            OBJ_CNODE:        res = {1'b1, LG_W'(sz) + LG_W'(CNODE_SLOT_LOG2)};
            OBJ_FRAME:        res = {1'b1, LG_W'(cfg.frame_size_log2)};
            OBJ_PAGE_TABLE:   res = {1'b1, LG_W'(cfg.page_table_size_log2)};
            OBJ_UNTYPED:      res = {1'b1, LG_W'(sz)};
            default:          res = '0;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

[sv/untyped_region_retype_allocator.sv]
`default_nettype none

// channel   | direction | ports                          | payload
// ----------+-----------+--------------------------------+---------------------------------
// s_axis    | in        | tvalid, tready, tdata, tuser   | one allocator request
// m_axis    | out       | tvalid, tready, tdata          | one result per request
// cfg       | in        | valid, ready, index, data      | register write
//
// one request per cycle sustained while the result side is not stalled; an accepted request
// passes from the input register through the placement logic into the result register
// the free-offset feedback through align, add and compare sets the cycle time
// synchronous active-low reset restores register defaults and empties the child table
// a stalled result holds the result register; the input register still takes one request
// config writes are always ready and take effect in the next cycle

module untyped_region_retype_allocator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // object_type[2:0], object_size_log2[7:3], child_index[15:8]
    input  wire logic [15:0] i_s_axis_tdata,
    // operation[1:0]
    input  wire logic [1:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // ok[0], object_address[32:1], bytes_remaining[64:33], active_children[69:65],
    // has_children[70], dev_region[71]
    output logic [71:0]      o_m_axis_tdata,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    logic           r_in_valid;
    urra_pkg::t_req r_req;
    logic           r_out_valid;
    urra_pkg::t_rsp r_rsp;
    urra_pkg::t_rsp core_rsp;
    urra_pkg::t_cfg cfg;
    logic           advance;
    logic           fire;
    logic           s_take;

    assign o_cfg_ready     = 1'b1;
    assign advance         = !r_out_valid || i_m_axis_tready;
    assign fire            = r_in_valid && advance;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign s_take          = i_s_axis_tvalid && o_s_axis_tready;

    urra_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    urra_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (r_req),
        .i_cfg   (cfg),
        .o_rsp   (core_rsp)
    );

    // input request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_req.operation        <= urra_pkg::t_op'(i_s_axis_tuser);
            r_req.object_type      <= urra_pkg::t_obj'(i_s_axis_tdata[2:0]);
            r_req.object_size_log2 <= i_s_axis_tdata[7:3];
            r_req.child_index      <= i_s_axis_tdata[15:8];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_rsp <= core_rsp;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_rsp;

endmodule

`default_nettype wire

[sv/urra_cfg_regs.sv]
`default_nettype none

module urra_cfg_regs (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_wr,
    input  wire logic [2:0]      i_index,
    input  wire logic [31:0]     i_data,
    output urra_pkg::t_cfg       o_cfg
);

    urra_pkg::t_cfg r_cfg;
    urra_pkg::t_cfg n_cfg;

    // register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            case (urra_pkg::t_cfg_idx'(i_index))
                urra_pkg::CFG_BASE_ADDRESS:           n_cfg.base_address = i_data;
                urra_pkg::CFG_REGION_SIZE_LOG2:       n_cfg.region_size_log2 = i_data[4:0];
                urra_pkg::CFG_DEVICE_REGION:          n_cfg.device_region = i_data[0];
                urra_pkg::CFG_ENDPOINT_SIZE_LOG2:     n_cfg.endpoint_size_log2 = i_data[4:0];
                urra_pkg::CFG_NOTIFICATION_SIZE_LOG2: n_cfg.notification_size_log2 = i_data[4:0];
                urra_pkg::CFG_THREAD_BLOCK_SIZE_LOG2: n_cfg.thread_block_size_log2 = i_data[4:0];
                urra_pkg::CFG_FRAME_SIZE_LOG2:        n_cfg.frame_size_log2 = i_data[4:0];
                urra_pkg::CFG_PAGE_TABLE_SIZE_LOG2:   n_cfg.page_table_size_log2 = i_data[4:0];
                default:                              n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_address           <= urra_pkg::RST_BASE_ADDRESS;
            r_cfg.region_size_log2       <= urra_pkg::RST_REGION_LOG2;
            r_cfg.device_region          <= 1'b0;
            r_cfg.endpoint_size_log2     <= urra_pkg::RST_ENDPOINT;
            r_cfg.notification_size_log2 <= urra_pkg::RST_NOTIFICATION;
            r_cfg.thread_block_size_log2 <= urra_pkg::RST_THREAD_BLOCK;
            r_cfg.frame_size_log2        <= urra_pkg::RST_FRAME;
            r_cfg.page_table_size_log2   <= urra_pkg::RST_PAGE_TABLE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[sv/urra_core.sv]
`default_nettype none

module urra_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_fire,
    input  wire urra_pkg::t_req i_req,
    input  wire urra_pkg::t_cfg i_cfg,
    output urra_pkg::t_rsp   o_rsp
);

    localparam int SW = urra_pkg::SIZE_W;
    localparam int CW = urra_pkg::CNT_W;
    localparam int AW = urra_pkg::ADDR_W;
    localparam int XW = urra_pkg::CNT_W + urra_pkg::CHILD_IDX_W;
    localparam int EW = urra_pkg::CNT_W + urra_pkg::ACT_W;

    logic [AW-1:0]                     r_free_offset, n_free_offset;
    logic [CW-1:0]                     r_child_count, n_child_count;
    logic [urra_pkg::MAX_CHILDREN-1:0] r_child_active, n_child_active;
    logic [CW-1:0]                     r_active_total, n_active_total;

    logic [urra_pkg::LG_W:0]   lg_info;
    logic                      lg_ok;
    logic [SW-1:0]             object_bytes;
    logic [SW-1:0]             mask;
    logic [SW-1:0]             aligned;
    logic [SW-1:0]             end_off;
    logic [SW-1:0]             total;
    logic                      fits;
    logic                      table_full;
    logic                      idx_in_range;
    logic                      idx_active;
    logic [AW-1:0]             total32;
    logic [EW-1:0]             act_ext;
    logic                      ok;
    logic [AW-1:0]             addr;

    // placement: align free offset up to object size and check fit
    always_comb begin
        lg_info      = urra_pkg::obj_log2(i_cfg, i_req.object_type, i_req.object_size_log2);
        lg_ok        = lg_info[urra_pkg::LG_W];
        object_bytes = SW'(1) << lg_info[urra_pkg::LG_W-1:0];
        mask         = object_bytes - SW'(1);
        aligned      = (SW'(r_free_offset) + mask) & ~mask;
        end_off      = aligned + object_bytes;
        total        = SW'(1) << i_cfg.region_size_log2;
        fits         = lg_ok && (end_off <= total);
    end

    // child table lookups
    assign table_full   = (r_child_count == CW'(urra_pkg::MAX_CHILDREN));
    assign idx_in_range = (XW'(i_req.child_index) < XW'(r_child_count));
    assign idx_active   = r_child_active[i_req.child_index[urra_pkg::IDX_W-1:0]];

    // next state per operation
    always_comb begin
        n_free_offset  = r_free_offset;
        n_child_count  = r_child_count;
        n_child_active = r_child_active;
        n_active_total = r_active_total;
        ok             = 1'b0;
        addr           = '0;
        case (i_req.operation)
            urra_pkg::OP_RETYPE: begin
                if (!table_full && fits) begin
                    n_child_active[r_child_count[urra_pkg::IDX_W-1:0]] = 1'b1;
                    n_child_count  = r_child_count + CW'(1);
                    n_active_total = r_active_total + CW'(1);
                    n_free_offset  = end_off[AW-1:0];
                    addr           = i_cfg.base_address + aligned[AW-1:0];
                    ok             = 1'b1;
                end
            end
            urra_pkg::OP_PROBE: begin
                if (fits) begin
                    addr = i_cfg.base_address + aligned[AW-1:0];
                    ok   = 1'b1;
                end
            end
            urra_pkg::OP_REVOKE_ALL: begin
                n_free_offset  = '0;
                n_child_count  = '0;
                n_child_active = '0;
                n_active_total = '0;
                ok             = 1'b1;
            end
            urra_pkg::OP_REVOKE_ONE: begin
                if (idx_in_range && idx_active) begin
                    n_child_active[i_req.child_index[urra_pkg::IDX_W-1:0]] = 1'b0;
                    n_active_total = r_active_total - CW'(1);
                end
                ok = 1'b1;
            end
            default: ok = 1'b0;
        endcase
    end

    // result fields from the post-step state
    always_comb begin
        total32                = AW'(1) << i_cfg.region_size_log2;
        act_ext                = EW'(n_active_total);
        o_rsp.ok               = ok;
        o_rsp.object_address   = addr;
        o_rsp.bytes_remaining  = (n_free_offset >= total32) ? '0 : total32 - n_free_offset;
        o_rsp.active_children  = act_ext[urra_pkg::ACT_W-1:0];
        o_rsp.has_children     = (n_active_total != '0);
        o_rsp.dev_region       = i_cfg.device_region;
    end

    // allocator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_offset  <= '0;
            r_child_count  <= '0;
            r_child_active <= '0;
            r_active_total <= '0;
        end else if (i_fire) begin
            r_free_offset  <= n_free_offset;
            r_child_count  <= n_child_count;
            r_child_active <= n_child_active;
            r_active_total <= n_active_total;
        end
    end

endmodule

`default_nettype wire
